### sv/mrf_pkg.sv
package mrf_pkg;

	// operation codes carried in the input tuser
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	// result status codes carried in the output tuser
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_DATA = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	localparam int unsigned WORD_W = 64;

	// input tuser, lowest bit first: operation, reader_id
	typedef struct packed {
		logic reader_id;
		op_t  operation;
	} in_user_t;

	// output tuser, lowest bits first: status, freed
	typedef struct packed {
		logic    freed;
		status_t status;
	} out_user_t;

endpackage

### sv/mrf_ram.sv
module mrf_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/multi_reader_fifo.sv
// multi_reader_fifo: a broadcast fifo of record words shared by READERS readers. an insert
// word (tuser operation insert) appends tdata at the tail; if DEPTH records are already held
// the word is dropped and status full comes back. a read word (tuser operation read) from
// reader reader_id returns the oldest record that reader has not yet seen and marks it seen;
// once every reader has seen the head record it is freed and freed is set in the result.
// a reader with nothing new, or a reader_id at or beyond READERS, gets status no_data with
// zero data. every input word yields exactly one result word. at accept an item updates the
// pointers and issues the record memory access; stage 1 then holds it while the registered
// memory read data arrives, and the result then waits in the output register. the next item
// is taken only once stage 1 is empty and the output register is free or being emptied, so
// only one item at a time is in flight ahead of the output register. records live in
// a single-port-write, registered-read memory; pointers and per-reader offsets are
// registers. no clearing pass is needed after reset.
module multi_reader_fifo #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned READERS    = 2,
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [mrf_pkg::WORD_W-1:0]  s_tdata,   // data_in
	input  mrf_pkg::in_user_t           s_tuser,   // operation, reader_id
	// result channel
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mrf_pkg::WORD_W-1:0]  m_tdata,   // data_out
	output mrf_pkg::out_user_t          m_tuser    // status, freed
);

	import mrf_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned SUM_W = CNT_W + 1;

	// pointer state
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] off_q [READERS];

	// stage 1: memory read in flight
	logic    s1_valid_q;
	logic    rd_s1;
	status_t status_s1;
	logic    freed_s1;

	// output register
	logic                  out_valid_q;
	logic [WORD_W-1:0]     out_data_q;
	status_t               out_status_q;
	logic                  out_freed_q;

	logic                  accept;
	logic                  is_insert;
	logic                  is_full;
	logic                  rd_ok;
	logic                  has_new;
	logic [CNT_W-1:0]      sel_off;
	logic [SUM_W-1:0]      wr_sum;
	logic [SUM_W-1:0]      rd_sum;
	logic [PTR_W-1:0]      wr_slot;
	logic [PTR_W-1:0]      rd_slot;
	logic [PTR_W-1:0]      head_inc;
	logic [CNT_W-1:0]      off_inc [READERS];
	logic                  all_read;
	logic                  do_write;
	logic                  do_read;
	status_t               status_nxt;
	logic [DATA_WIDTH-1:0] ram_rdata;

	// one item in flight at a time; stage 1 always moves on to the output register
	assign s_tready  = !s1_valid_q && (!out_valid_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign is_insert = (s_tuser.operation == OP_INSERT);
	assign is_full   = (fill_q == CNT_W'(DEPTH));

	// offset of the requesting reader; ids past READERS never match
	always_comb begin
		sel_off = '0;
		rd_ok   = 1'b0;
		for (int i = 0; i < READERS; i++) begin
			if (int'(s_tuser.reader_id) == i) begin
				sel_off = off_q[i];
				rd_ok   = 1'b1;
			end
		end
	end

	assign has_new = rd_ok && (sel_off < fill_q);

	// head plus offset, wrapped into the ring
	assign wr_sum  = SUM_W'(head_q) + SUM_W'(fill_q);
	assign rd_sum  = SUM_W'(head_q) + SUM_W'(sel_off);
	assign wr_slot = (wr_sum >= SUM_W'(DEPTH)) ? PTR_W'(wr_sum - SUM_W'(DEPTH))
	                                           : PTR_W'(wr_sum);
	assign rd_slot = (rd_sum >= SUM_W'(DEPTH)) ? PTR_W'(rd_sum - SUM_W'(DEPTH))
	                                           : PTR_W'(rd_sum);
	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

	assign do_write = accept && is_insert && !is_full;
	assign do_read  = accept && !is_insert && has_new;

	// bump the reader's offset; head is freed once every offset is past it
	always_comb begin
		all_read = 1'b1;
		for (int i = 0; i < READERS; i++) begin
			off_inc[i] = off_q[i];
			if (int'(s_tuser.reader_id) == i) begin
				off_inc[i] = off_q[i] + CNT_W'(1);
			end
			if (off_inc[i] == '0) begin
				all_read = 1'b0;
			end
		end
	end

	always_comb begin
		if (is_insert) begin
			status_nxt = is_full ? ST_FULL : ST_OK;
		end else begin
			status_nxt = has_new ? ST_OK : ST_NO_DATA;
		end
	end

	mrf_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (do_write),
		.waddr (wr_slot),
		.wdata (s_tdata[DATA_WIDTH-1:0]),
		.re    (do_read),
		.raddr (rd_slot),
		.rdata (ram_rdata)
	);

	// pointer and offset update at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			for (int i = 0; i < READERS; i++) begin
				off_q[i] <= '0;
			end
		end else if (do_write) begin
			fill_q <= fill_q + CNT_W'(1);
		end else if (do_read) begin
			if (all_read) begin
				head_q <= head_inc;
				fill_q <= fill_q - CNT_W'(1);
				for (int i = 0; i < READERS; i++) begin
					off_q[i] <= off_inc[i] - CNT_W'(1);
				end
			end else begin
				for (int i = 0; i < READERS; i++) begin
					off_q[i] <= off_inc[i];
				end
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= do_read;
			status_s1 <= status_nxt;
			freed_s1  <= do_read && all_read;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_q) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			out_data_q   <= rd_s1 ? WORD_W'(ram_rdata) : '0;
			out_status_q <= status_s1;
			out_freed_q  <= freed_s1;
		end
	end

	assign m_tvalid       = out_valid_q;
	assign m_tdata        = out_data_q;
	assign m_tuser.status = out_status_q;
	assign m_tuser.freed  = out_freed_q;

endmodule

### tb/mrf_checker.sv
module mrf_checker #(
	parameter int unsigned DEPTH   = 16,
	parameter int unsigned READERS = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [mrf_pkg::WORD_W-1:0]  s_tdata,   // data_in
	input  mrf_pkg::in_user_t           s_tuser,   // operation, reader_id
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [mrf_pkg::WORD_W-1:0]  m_tdata,   // data_out
	input  mrf_pkg::out_user_t          m_tuser,   // status, freed
	output int                          errors,
	output int                          pending,
	output int                          n_insert,
	output int                          n_full,
	output int                          n_read,
	output int                          n_no_data,
	output int                          n_freed
);
	timeunit 1ns;
	timeprecision 1ps;

	import mrf_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	typedef struct packed {
		status_t             status;
		logic [WORD_W-1:0]   data;
		logic                freed;
	} rec_result_t;

	// shadow of the shared record fifo
	logic [WORD_W-1:0] rec_mem [DEPTH];
	logic [PTR_W-1:0]  head_slot;
	logic [CNT_W-1:0]  rec_count;
	logic [CNT_W-1:0]  seen_cnt [READERS];

	rec_result_t       results_due [$];

	// head plus offset, wrapped into the ring
	function automatic logic [PTR_W-1:0] slot_of(input logic [CNT_W-1:0] off);
		int s;
		s = int'(head_slot) + int'(off);
		if (s >= int'(DEPTH)) s -= int'(DEPTH);
		return PTR_W'(s);
	endfunction

	task automatic apply_word(input op_t op, input logic rid, input logic [WORD_W-1:0] word,
		output rec_result_t r);
		logic [PTR_W-1:0] slot;
		logic             all_seen;
		r.status = ST_OK;
		r.data   = '0;
		r.freed  = 1'b0;
		if (op == OP_INSERT) begin
			if (rec_count >= CNT_W'(DEPTH)) begin
				r.status = ST_FULL;
			end else begin
				slot = slot_of(rec_count);
				rec_mem[slot] = word;
				rec_count++;
			end
		end else if (rid >= READERS || seen_cnt[rid] >= rec_count) begin
			r.status = ST_NO_DATA;
		end else begin
			slot = slot_of(seen_cnt[rid]);
			r.data = rec_mem[slot];
			seen_cnt[rid]++;
			all_seen = 1'b1;
			for (int i = 0; i < READERS; i++)
				if (seen_cnt[i] == 0) all_seen = 1'b0;
			// head record seen by everyone: retire it
			if (all_seen) begin
				for (int i = 0; i < READERS; i++) seen_cnt[i]--;
				head_slot = slot_of(CNT_W'(1));
				rec_count--;
				r.freed = 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rec_result_t r;
		if (!arst_n) begin
			head_slot = '0;
			rec_count = '0;
			for (int i = 0; i < READERS; i++) seen_cnt[i] = '0;
			results_due.delete();
			errors    = 0;
			pending   = 0;
			n_insert  = 0;
			n_full    = 0;
			n_read    = 0;
			n_no_data = 0;
			n_freed   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_word(s_tuser.operation, s_tuser.reader_id, s_tdata, r);
				results_due.push_back(r);
				if (s_tuser.operation == OP_INSERT) n_insert++;
				else n_read++;
				if (r.status == ST_FULL) n_full++;
				if (r.status == ST_NO_DATA) n_no_data++;
				if (r.freed) n_freed++;
			end
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					errors++;
					$display("%0t unexpected result: status %0d data %h freed %b",
						$time, m_tuser.status, m_tdata, m_tuser.freed);
				end else begin
					r = results_due.pop_front();
					if (m_tuser.status !== r.status || m_tdata !== r.data ||
						m_tuser.freed !== r.freed) begin
						errors++;
						$display({"%0t mismatch: expected status %0d data %h freed %b,",
							" got status %0d data %h freed %b"},
							$time, r.status, r.data, r.freed,
							m_tuser.status, m_tdata, m_tuser.freed);
					end
				end
			end
			pending = results_due.size();
		end
	end

endmodule

### tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mrf_pkg::*;

	localparam int RAND_WORDS = 1625;  // random words after the directed part
	localparam int CALM_WORDS = 200;   // tail of the run with no idling at all

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [WORD_W-1:0]  s_tdata;   // data_in
	in_user_t           s_tuser;   // operation, reader_id
	logic               m_tvalid;
	logic               m_tready;
	logic [WORD_W-1:0]  m_tdata;   // data_out
	out_user_t          m_tuser;   // status, freed

	int errors, pending;
	int n_insert, n_full, n_read, n_no_data, n_freed;

	// idling odds in percent, changed from phase to phase
	int gap_pct;
	int stall_pct;

	multi_reader_fifo u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	mrf_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.errors    (errors),
		.pending   (pending),
		.n_insert  (n_insert),
		.n_full    (n_full),
		.n_read    (n_read),
		.n_no_data (n_no_data),
		.n_freed   (n_freed)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#5ms;
		$display("timeout with %0d results still due", pending);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// offer one word and hold it until the block takes it
	task automatic send_word(input op_t op, input logic rid, input logic [WORD_W-1:0] d);
		in_user_t u;
		u.operation = op;
		u.reader_id = rid;
		// optional sender gap with valid held low
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= u;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// result side back-pressure in bursts
	initial begin
		m_tready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		int sent;
		int chunk;
		int ins_pct;
		int r1_pct;
		logic rid;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		gap_pct   = 0;
		stall_pct = 0;
		arst_n    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty fifo, both readers ask first
		send_word(OP_READ, 1'b0, rand_word());
		send_word(OP_READ, 1'b1, rand_word());
		// extremes of the record word
		send_word(OP_INSERT, 1'b1, '0);
		send_word(OP_INSERT, 1'b0, '1);
		// reader 0 runs ahead, then finds nothing new while reader 1 lags
		send_word(OP_READ, 1'b0, '1);
		send_word(OP_READ, 1'b0, '0);
		send_word(OP_READ, 1'b0, rand_word());
		// reader 1 catches up, each read frees the head
		send_word(OP_READ, 1'b1, '0);
		send_word(OP_READ, 1'b1, '1);
		// fill the store to the brim with alternating patterns, then overflow
		for (int i = 0; i < 16; i++)
			send_word(OP_INSERT, i[0], i[1] ? {16{4'ha}} : {16{4'h5}});
		send_word(OP_INSERT, 1'b0, rand_word());

		// random phases: insert-heavy, read-heavy and skewed reader mixes
		sent = 0;
		while (sent < RAND_WORDS) begin
			chunk = $urandom_range(20, 80);
			case ($urandom_range(0, 3))
				0: ins_pct = 15;
				1: ins_pct = 85;
				2: ins_pct = 50;
				default: ins_pct = $urandom_range(10, 90);
			endcase
			// share of reads that go to reader 1, extremes make one reader lag
			case ($urandom_range(0, 2))
				0: r1_pct = $urandom_range(0, 10);
				1: r1_pct = $urandom_range(90, 100);
				default: r1_pct = $urandom_range(30, 70);
			endcase
			if (sent + chunk > RAND_WORDS - CALM_WORDS) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
				stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
			end
			for (int i = 0; i < chunk && sent < RAND_WORDS; i++) begin
				rid = ($urandom_range(1, 100) <= r1_pct);
				if ($urandom_range(1, 100) <= ins_pct)
					send_word(OP_INSERT, 1'($urandom_range(0, 1)), rand_word());
				else
					send_word(OP_READ, rid, rand_word());
				sent++;
			end
		end
		s_tvalid <= 1'b0;

		// drain: everything due must come back before the report
		do @(negedge clk); while (pending != 0);
		repeat (8) @(negedge clk);

		$display("covered %0d inserts (%0d dropped on a full store) and %0d reads",
			n_insert, n_full, n_read);
		$display("reads with nothing new: %0d, head records freed: %0d", n_no_data, n_freed);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d errors", errors);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
